### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - assertion macros for the array list block
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ALIST_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alist check failed");

// next-cycle implication
`define ALIST_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alist check failed");

`endif

### src/alist_pkg.sv
// ----------------------------------------------------------------------------
// alist_pkg - shared types and constants of the array list
// Opcodes, status codes, field widths and the cell command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package alist_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // request / response field widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // cell index and fill widths cover the largest supported capacity (256)
    localparam int IDX_W  = 8;
    localparam int FILL_W = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OPC_PUSH_FRONT = 3'd0,
        OPC_PUSH_BACK  = 3'd1,
        OPC_INSERT     = 3'd2,
        OPC_POP_FRONT  = 3'd3,
        OPC_POP_BACK   = 3'd4,
        OPC_DELETE     = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_INSERT    = 2'd1,
        CELL_POP_FRONT = 2'd2,
        CELL_DELETE    = 2'd3
    } cell_op_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  at;    // slot that takes the new word
        logic [FILL_W-1:0] fill;  // entries currently held
    } cell_cmd_t;

endpackage

`default_nettype wire

### src/alist_req_if.sv
// ----------------------------------------------------------------------------
// alist_req_if - request channel of the array list
// Valid/ready handshake carrying opcode, value and position.
// ----------------------------------------------------------------------------
`default_nettype none

interface alist_req_if
    import alist_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           position;

    modport source (output valid, output opcode, output value, output position, input ready);
    modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

`default_nettype wire

### src/alist_rsp_if.sv
// ----------------------------------------------------------------------------
// alist_rsp_if - response channel of the array list
// Valid/ready handshake carrying status, count and front entry.
// ----------------------------------------------------------------------------
`default_nettype none

interface alist_rsp_if
    import alist_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         count;
    logic signed [VALUE_W-1:0]  front_value;

    modport source (output valid, output status, output count, output front_value, input ready);
    modport sink   (input valid, input status, input count, input front_value, output ready);
endinterface

`default_nettype wire

### src/array_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// array_list_insert_delete_top - bounded ordered list of signed words
// A row of CAPACITY cells that shift as one to open or close gaps.
// ----------------------------------------------------------------------------
// A user sends requests on req: push front, push back, insert at a position,
// pop front, pop back, or delete the first entry equal to value. Each request
// gives exactly one response on rsp: a status (ok, empty, full, bad position,
// not found), the entry count after the request and the entry then at the
// front (zero when the list is empty). A request that fails leaves the list
// untouched. The list lives in a chain of cells, one entry per cell; every
// cell moves in the same clock, so each request is done in the cycle it is
// accepted and its response shows up registered on the next cycle. The
// block takes one request per clock as long as rsp is taken each cycle;
// a response that waits stalls req. The critical path of a delete is the
// compare in each cell plus the match ripple along the row, which grows
// with CAPACITY. Stored words are DATA_WIDTH bits: the low bits of value
// are kept and the front entry is sign-extended back to 32 bits. Entries
// have no reset; only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_insert_delete_top
    import alist_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    alist_req_if.sink   req,
    alist_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // ---- state ----
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    status_t          status_reg;
    status_t          status_next;

    // ---- cell row ----
    cell_cmd_t             cmd;
    cell_op_t              cell_op;
    logic [IDX_W-1:0]      cell_at;
    logic [DATA_WIDTH-1:0] din;
    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic [CAPACITY:0]     seen_chain;

    logic accept;
    logic full;
    logic empty;
    logic pos_ok;
    logic found;

    // a waiting response holds off the next request
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign pos_ok = (CMP_W'(req.position) < CMP_W'(count_reg));
    assign found  = seen_chain[CAPACITY];

    // low DATA_WIDTH bits of the request word, zero-filled above 32 bits
    assign din = DATA_WIDTH'(64'($unsigned(req.value)));

    // ---- request decode ----
    always_comb
    begin
        status_next = ST_OK;
        count_next  = count_reg;
        cell_op     = CELL_HOLD;
        cell_at     = '0;
        case (opcode_t'(req.opcode))
            OPC_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cell_op    = CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            OPC_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // push back is an insert at the first free slot
                    cell_op    = CELL_INSERT;
                    cell_at    = IDX_W'(count_reg);
                    count_next = count_reg + 1'b1;
                end
            end
            OPC_INSERT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    status_next = ST_BADPOS;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cell_op    = CELL_INSERT;
                    cell_at    = IDX_W'(req.position);
                    count_next = count_reg + 1'b1;
                end
            end
            OPC_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cell_op    = CELL_POP_FRONT;
                    count_next = count_reg - 1'b1;
                end
            end
            OPC_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            OPC_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (found)
                begin
                    // no match means no cell shifts
                    cell_op    = CELL_DELETE;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // cells move only on an accepted request
    assign cmd.op   = accept ? cell_op : CELL_HOLD;
    assign cmd.at   = cell_at;
    assign cmd.fill = FILL_W'(count_reg);

    assign seen_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = din;  // never taken: slot 0 is never above cmd.at
        end
        else
        begin : g_mid_left
            assign left_data = cell_q[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_q[i];  // slot past the end, don't care
        end
        else
        begin : g_mid_right
            assign right_data = cell_q[i+1];
        end

        alist_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (i)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmd),
            .din      (din),
            .left     (left_data),
            .right    (right_data),
            .seen_in  (seen_chain[i]),
            .seen_out (seen_chain[i+1]),
            .entry    (cell_q[i])
        );
    end

    // ---- count and response ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
        end
    end

    // list state cannot change while a response waits, so the front and
    // count are read straight from the registers
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.count       = COUNT_W'(count_reg);
    assign rsp.front_value = empty ? '0 : VALUE_W'(signed'(cell_q[0]));

endmodule

`default_nettype wire

### src/alist_cell.sv
// ----------------------------------------------------------------------------
// alist_cell - one slot of the list
// Holds one entry; loads the request word, takes the left neighbor
// (open a gap) or the right neighbor (close a gap). Ripples the delete match.
// ----------------------------------------------------------------------------
`default_nettype none

module alist_cell
    import alist_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int IDX        = 0
)
(
    input  wire logic                  clk,
    input  wire cell_cmd_t             cmd,
    input  wire logic [DATA_WIDTH-1:0] din,
    input  wire logic [DATA_WIDTH-1:0] left,
    input  wire logic [DATA_WIDTH-1:0] right,
    input  wire logic                  seen_in,
    output logic                       seen_out,
    output logic [DATA_WIDTH-1:0]      entry
);

    localparam logic [IDX_W-1:0]  MY_IDX  = IDX_W'(IDX);
    localparam logic [FILL_W-1:0] MY_FILL = FILL_W'(IDX);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  match;

    // only live slots take part in the search
    assign match    = (MY_FILL < cmd.fill) && (entry_reg == din);
    assign seen_out = seen_in | match;
    assign entry    = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (MY_IDX == cmd.at)
                begin
                    entry_next = din;
                end
                else if (MY_IDX > cmd.at)
                begin
                    entry_next = left;
                end
            end
            CELL_POP_FRONT:
            begin
                entry_next = right;
            end
            CELL_DELETE:
            begin
                // the first match and every slot above it close the gap
                if (seen_out)
                begin
                    entry_next = right;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

### src/alist_checker.sv
// ----------------------------------------------------------------------------
// alist_checker - port-level checks of the array list
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module alist_checker
    import alist_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      req_ready,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [STATUS_W-1:0]       rsp_status,
    input wire logic [COUNT_W-1:0]        rsp_count,
    input wire logic signed [VALUE_W-1:0] rsp_front_value
);

    // a stalled response holds
    `ALIST_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_front_value))

    // no new request while the response waits
    `ALIST_ASSERT_IMP(a_stall_blocks, rsp_valid && !rsp_ready, !req_ready)

    // empty and full reports agree with the count
    `ALIST_ASSERT_IMP(a_empty_count, rsp_valid && rsp_status == ST_EMPTY, rsp_count == '0)
    `ALIST_ASSERT_IMP(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_count == COUNT_W'(CAPACITY))

    // an empty list shows a zero front
    `ALIST_ASSERT_IMP(a_empty_front, rsp_valid && rsp_count == '0 && CAPACITY < 32, rsp_front_value == '0)

endmodule

bind array_list_insert_delete_top alist_checker #(
    .CAPACITY (CAPACITY)
) u_alist_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_count       (rsp.count),
    .rsp_front_value (rsp.front_value)
);

`default_nettype wire
